// ===== design/spq_pkg.sv =====
package spq_pkg;

    // Default number of entries the queue can hold.
    localparam int unsigned DEF_CAPACITY = 16;

    // Fixed field widths of the transaction ports.
    localparam int unsigned ITEM_W   = 32;
    localparam int unsigned PRIO_W   = 32;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;        // latch the accepted transaction, start slot at count
        logic    rd_slot;     // read the entry just above the free slot
        logic    rd_head;     // read the head entry
        logic    rd_idx;      // read the entry at the requested index
        logic    move;        // write the read entry into the free slot, slot moves down
        logic    place;       // write the new entry into the free slot, count grows
        logic    pop;         // drop the head entry
        logic    clear;       // empty the queue
        logic    emit;        // present a result
        logic    emit_rd;     // result value comes from the read data
        t_status emit_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  idx_ok;
        logic  slot_zero;
        logic  ge;            // stored priority is not below the new one
    } t_dp_stat;

endpackage

// ===== design/spq_ctrl.sv =====
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import spq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_RD    = 5'b00100,
        S_CMP   = 5'b01000,
        S_FETCH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.func)
                    FUNC_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_FULL;
                            n_state           = S_IDLE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    FUNC_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_EMPTY;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.rd_head = 1'b1;
                            n_state       = S_FETCH;
                        end
                    end
                    FUNC_READ: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_idx = 1'b1;
                            n_state      = S_FETCH;
                        end else begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_BADIDX;
                            n_state           = S_IDLE;
                        end
                    end
                    FUNC_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.emit  = 1'b1;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                if (i_stat.slot_zero) begin
                    o_cmd.place = 1'b1;
                    o_cmd.emit  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.ge) begin
                    o_cmd.place = 1'b1;
                    o_cmd.emit  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.move = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_FETCH: begin
                o_cmd.emit    = 1'b1;
                o_cmd.emit_rd = 1'b1;
                o_cmd.pop     = (i_stat.func == FUNC_POP);
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/spq_dp.sv =====
module spq_dp #(
    parameter int unsigned CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spq_pkg::t_dp_cmd                    i_cmd,
    output spq_pkg::t_dp_stat                   o_stat,
    input  logic [spq_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [spq_pkg::ITEM_W-1:0]   i_item,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [spq_pkg::INDEX_W-1:0]         i_index,
    output logic                                o_valid,
    output logic signed [spq_pkg::ITEM_W-1:0]   o_value,
    output logic [spq_pkg::COUNT_W-1:0]         o_count,
    output logic [spq_pkg::STATUS_W-1:0]        o_status
);
    import spq_pkg::*;

    localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (CW > INDEX_W) ? CW : INDEX_W;

    // Entry storage, kept as a ring: logical position 0 sits at r_head.
    logic [ITEM_W-1:0]        item_mem [CAPACITY];
    logic signed [PRIO_W-1:0] prio_mem [CAPACITY];

    t_func                    r_func;
    logic signed [ITEM_W-1:0] r_item;
    logic signed [PRIO_W-1:0] r_prio;
    logic [INDEX_W-1:0]       r_index;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_slot;
    logic [PW-1:0]            r_head;
    logic [ITEM_W-1:0]        r_rd_item;
    logic signed [PRIO_W-1:0] r_rd_prio;
    logic                     r_valid;
    logic [ITEM_W-1:0]        r_res_value;
    logic [COUNT_W-1:0]       r_res_count;
    t_status                  r_res_status;

    logic [PW-1:0]            w_rd_logical;
    logic [PW-1:0]            w_rd_addr;
    logic [PW-1:0]            w_wr_addr;
    logic                     w_we;
    logic [ITEM_W-1:0]        w_wr_item;
    logic signed [PRIO_W-1:0] w_wr_prio;

    function automatic logic [PW-1:0] f_wrap(input logic [PW:0] sum);
        logic [PW:0] lim;
        lim = (PW + 1)'(CAPACITY);
        if (sum >= lim) begin
            return PW'(sum - lim);
        end
        return PW'(sum);
    endfunction

    always_comb begin
        if (i_cmd.rd_slot) begin
            w_rd_logical = PW'(r_slot - CW'(1));
        end else if (i_cmd.rd_idx) begin
            w_rd_logical = PW'(r_index);
        end else if (i_cmd.rd_head) begin
            w_rd_logical = '0;
        end else begin
            w_rd_logical = '0;
        end
    end

    assign w_rd_addr = f_wrap({1'b0, r_head} + {1'b0, w_rd_logical});
    assign w_wr_addr = f_wrap({1'b0, r_head} + {1'b0, PW'(r_slot)});
    assign w_we      = i_cmd.move | i_cmd.place;
    assign w_wr_item = i_cmd.move ? r_rd_item : r_item;
    assign w_wr_prio = i_cmd.move ? r_rd_prio : r_prio;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            item_mem[w_wr_addr] <= w_wr_item;
            prio_mem[w_wr_addr] <= w_wr_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_item <= item_mem[w_rd_addr];
        r_rd_prio <= prio_mem[w_rd_addr];
    end

    always_comb begin
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.place) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.emit;
            if (i_cmd.pop) begin
                r_head <= f_wrap({1'b0, r_head} + (PW + 1)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_func);
            r_item  <= i_item;
            r_prio  <= i_priority_req;
            r_index <= i_index;
            r_slot  <= r_count;
        end else if (i_cmd.move) begin
            r_slot <= r_slot - CW'(1);
        end
        if (i_cmd.emit) begin
            r_res_value  <= i_cmd.emit_rd ? r_rd_item : '0;
            r_res_count  <= COUNT_W'(n_count);
            r_res_status <= i_cmd.emit_status;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.full      = (r_count == CW'(CAPACITY));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.idx_ok    = (XW'(r_index) < XW'(r_count));
    assign o_stat.slot_zero = (r_slot == '0);
    assign o_stat.ge        = (r_rd_prio >= r_prio);

    assign o_valid  = r_valid;
    assign o_value  = r_res_value;
    assign o_count  = r_res_count;
    assign o_status = r_res_status;

endmodule

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue. Up to CAPACITY entries are held in priority order,
// highest first; entries of equal priority leave in the order they arrived.
// A transaction is taken on a rising edge where start is high and busy is
// low, and every transaction produces exactly one result, shown for a single
// cycle with o_valid high. The receiver cannot hold a result off, so it must
// capture o_value, o_count and o_status in the cycle that o_valid is high.
// A result is emitted from the execute state for clear and for any rejected
// operation (push on full, pop on empty, bad index), and from the fetch state,
// after an entry memory read, for pop and read-at; the result registers then
// show it. A push walks down from the tail of the queue, reading the entry
// above the free slot, comparing priorities and moving that entry down one
// place, until the free slot reaches the head or lies below an entry of equal
// or higher priority; the new entry is then placed there. The next transaction
// can be taken in the very cycle the result is shown. Storage is a ring
// addressed from a head pointer, so a pop does not shift the queue. Entries
// need no clearing after reset.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [spq_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [spq_pkg::ITEM_W-1:0] i_item,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_priority_req,
    input  logic [spq_pkg::INDEX_W-1:0]       i_index,
    output logic                              o_valid,
    output logic signed [spq_pkg::ITEM_W-1:0] o_value,
    output logic [spq_pkg::COUNT_W-1:0]       o_count,
    output logic [spq_pkg::STATUS_W-1:0]      o_status
);
    import spq_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // The datapath holds the entry memory, the count, the head pointer and
    // the result registers.
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_func),
        .i_item         (i_item),
        .i_priority_req (i_priority_req),
        .i_index        (i_index),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_count        (o_count),
        .o_status       (o_status)
    );

endmodule

// ===== design/spq_checker.sv =====
module spq_assertions (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [spq_pkg::ITEM_W-1:0] o_value,
    input logic [spq_pkg::COUNT_W-1:0]       o_count,
    input logic [spq_pkg::STATUS_W-1:0]      o_status
);
    import spq_pkg::*;

    // A taken transaction always raises busy in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Results are single-cycle strobes and never come back to back.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in consecutive cycles");

    // Any flagged result carries a zero value.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_value == '0))
        else $error("flagged result with non-zero value");

    // A pop on empty can only report an empty queue.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with non-zero count");

endmodule

bind sorted_priority_queue spq_assertions u_spq_assertions (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_value  (o_value),
    .o_count  (o_count),
    .o_status (o_status)
);

// ===== tb/spq_checker.sv =====
`timescale 1ns / 1ps

module spq_checker #(
    parameter int unsigned CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [spq_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [spq_pkg::ITEM_W-1:0] i_item,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_priority_req,
    input  logic [spq_pkg::INDEX_W-1:0]       i_index,
    input  logic                              i_valid,
    input  logic signed [spq_pkg::ITEM_W-1:0] i_value,
    input  logic [spq_pkg::COUNT_W-1:0]       i_count,
    input  logic [spq_pkg::STATUS_W-1:0]      i_status,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_full_seen,
    output int                                o_empty_seen,
    output int                                o_badidx_seen
);

    import spq_pkg::*;

    typedef struct packed {
        logic [ITEM_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } outcome_t;

    outcome_t                 outcome_q[$];
    logic [ITEM_W-1:0]        item_mem [CAPACITY];
    logic signed [PRIO_W-1:0] prio_mem [CAPACITY];
    int                       entries = 0;
    int                       fails = 0;
    int                       checked = 0;
    int                       full_seen = 0;
    int                       empty_seen = 0;
    int                       badidx_seen = 0;

    // Applies one transaction to the shadow queue and records the result it must give.
    task automatic predict_outcome(input t_func op, input logic [ITEM_W-1:0] itm,
                                   input logic signed [PRIO_W-1:0] pr,
                                   input logic [INDEX_W-1:0] ix);
        outcome_t want;
        int       slot;
        want.value  = '0;
        want.status = ST_OK;
        case (op)
            FUNC_PUSH: begin
                if (entries >= int'(CAPACITY)) begin
                    want.status = ST_FULL;
                end else begin
                    // New entry goes behind every entry of equal or higher priority.
                    slot = 0;
                    while (slot < entries && prio_mem[slot] >= pr)
                        slot++;
                    for (int k = entries; k > slot; k--) begin
                        item_mem[k] = item_mem[k-1];
                        prio_mem[k] = prio_mem[k-1];
                    end
                    item_mem[slot] = itm;
                    prio_mem[slot] = pr;
                    entries++;
                end
            end
            FUNC_POP: begin
                if (entries == 0) begin
                    want.status = ST_EMPTY;
                end else begin
                    want.value = item_mem[0];
                    for (int k = 0; k + 1 < entries; k++) begin
                        item_mem[k] = item_mem[k+1];
                        prio_mem[k] = prio_mem[k+1];
                    end
                    entries--;
                end
            end
            FUNC_READ: begin
                if (int'(ix) < entries)
                    want.value = item_mem[ix];
                else
                    want.status = ST_BADIDX;
            end
            default: begin
                entries = 0;
            end
        endcase
        want.count = COUNT_W'(entries);
        outcome_q.push_back(want);
    endtask

    always @(posedge i_clk) begin : watch
        outcome_t want;
        if (!i_rst_n) begin
            entries = 0;
            outcome_q.delete();
        end else begin
            // Results are compared before the new transaction is predicted, so a result
            // shown in the cycle of the next acceptance is matched against older work.
            if (i_valid) begin
                if (outcome_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result: value %0d count %0d status %0d",
                                 i_value, i_count, i_status);
                    fails++;
                end else begin
                    want = outcome_q.pop_front();
                    checked++;
                    case (want.status)
                        ST_FULL:   full_seen++;
                        ST_EMPTY:  empty_seen++;
                        ST_BADIDX: badidx_seen++;
                        default:   ;
                    endcase
                    if (i_value !== want.value || i_count !== want.count ||
                        i_status !== want.status) begin
                        if (fails < 10)
                            $display("mismatch at %0t: expected value %0d count %0d status %0d, got value %0d count %0d status %0d",
                                     $realtime, $signed(want.value), want.count,
                                     want.status, i_value, i_count, i_status);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy)
                predict_outcome(t_func'(i_func), i_item, i_priority_req, i_index);
        end
        o_fail_count  <= fails;
        o_pending     <= outcome_q.size();
        o_checked     <= checked;
        o_full_seen   <= full_seen;
        o_empty_seen  <= empty_seen;
        o_badidx_seen <= badidx_seen;
    end

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Test bench for the sorted priority queue. The top only generates transactions and gives
// the verdict; all prediction and comparison lives in the checker instance beside the
// block, which watches the command and result channels directly.
module tb_sorted_priority_queue;

    import spq_pkg::*;

    localparam int unsigned CAP = DEF_CAPACITY;

    // The slowest transaction is a push into a full-but-one queue that walks to the head,
    // and even with the longest gap the sender leaves, this limit is ample.
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_LEN     = 150;
    localparam int TAIL_CYCLES   = 4 * CAP;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [FUNC_W-1:0]         i_func;
    logic signed [ITEM_W-1:0]  i_item;
    logic signed [PRIO_W-1:0]  i_priority_req;
    logic [INDEX_W-1:0]        i_index;
    logic                      o_valid;
    logic signed [ITEM_W-1:0]  o_value;
    logic [COUNT_W-1:0]        o_count;
    logic [STATUS_W-1:0]       o_status;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;
    int badidx_seen;

    // Transactions issued per operation, and a rough idea of how full the queue is, used
    // only to steer the random part towards the full and empty boundaries.
    int issued [4];
    int fill;
    int burst_left;
    bit steady;

    sorted_priority_queue #(
        .CAPACITY (CAP)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_item         (i_item),
        .i_priority_req (i_priority_req),
        .i_index        (i_index),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_count        (o_count),
        .o_status       (o_status)
    );

    spq_checker #(
        .CAPACITY (CAP)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_item         (i_item),
        .i_priority_req (i_priority_req),
        .i_index        (i_index),
        .i_valid        (o_valid),
        .i_value        (o_value),
        .i_count        (o_count),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen),
        .o_badidx_seen  (badidx_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Presents one transaction and holds it until the block takes it. The task returns in
    // the time step of the accepting edge, so the caller may present the next transaction
    // straight away without start ever dropping in between.
    task automatic send_txn(input t_func op, input logic [ITEM_W-1:0] itm,
                            input logic [PRIO_W-1:0] pr, input logic [INDEX_W-1:0] ix);
        start          <= 1'b1;
        i_func         <= op;
        i_item         <= itm;
        i_priority_req <= pr;
        i_index        <= ix;
        do
            @(posedge i_clk);
        while (busy);
        issued[int'(op)]++;
        case (op)
            FUNC_PUSH:  if (fill < int'(CAP)) fill++;
            FUNC_POP:   if (fill > 0) fill--;
            FUNC_CLEAR: fill = 0;
            default:    ;
        endcase
    endtask

    // The sender works in bursts. At the end of each burst it drops start for a random
    // number of cycles, which lands the gap on whatever stage the block has reached. In
    // steady stretches there are no gaps at all.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if (!steady) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Priorities are drawn mostly from a narrow band so that ties are common, which is
    // where the arrival order of equal priorities shows; extremes and full-range values
    // make up the rest.
    function automatic logic [PRIO_W-1:0] pick_priority();
        int mode;
        mode = $urandom_range(0, 7);
        case (mode)
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return PRIO_W'(int'($urandom_range(0, 7)) - 4);
        endcase
    endfunction

    // Half the reads use any index; the others sit around the current count so that
    // the last valid entry and the first invalid index are both hit often.
    function automatic logic [INDEX_W-1:0] pick_index();
        int k;
        if ($urandom_range(0, 1) == 1)
            return INDEX_W'($urandom_range(0, 15));
        k = fill + int'($urandom_range(0, 2)) - 1;
        if (k < 0)
            k = 0;
        if (k > 15)
            k = 15;
        return INDEX_W'(k);
    endfunction

    initial begin : stimulus
        int    push_pct;
        int    roll;
        t_func op;

        start          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_func         <= FUNC_PUSH;
        i_item         <= '0;
        i_priority_req <= '0;
        i_index        <= '0;
        fill       = 0;
        burst_left = 0;
        steady     = 1'b0;
        for (int k = 0; k < 4; k++)
            issued[k] = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Everything on the empty queue first: pop, two bad reads, clear.
        send_txn(FUNC_POP,   32'h1234_5678, 32'h0, 4'd0);   pace();
        send_txn(FUNC_READ,  32'h0,         32'h0, 4'd0);   pace();
        send_txn(FUNC_READ,  32'h0,         32'h0, 4'd15);  pace();
        send_txn(FUNC_CLEAR, 32'h0,         32'h0, 4'd0);   pace();

        // Fill the queue with extreme items and priorities, including ties at zero and
        // at minus one and one, then try one push too many.
        send_txn(FUNC_PUSH, 32'h7FFF_FFFF, 32'h0000_0000, 4'd0);  pace();
        send_txn(FUNC_PUSH, 32'h8000_0000, 32'h0000_0000, 4'd0);  pace();
        send_txn(FUNC_PUSH, 32'h0000_0000, 32'h7FFF_FFFF, 4'd0);  pace();
        send_txn(FUNC_PUSH, 32'hFFFF_FFFF, 32'h8000_0000, 4'd0);  pace();
        for (int k = 0; k < int'(CAP) - 4; k++) begin
            send_txn(FUNC_PUSH, ITEM_W'(k) * 32'h1357_9BDF, PRIO_W'((k % 3) - 1), 4'd0);
            pace();
        end
        send_txn(FUNC_PUSH, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 4'd0);  pace();

        // Reads at both ends of a full queue, a pop, then a read just past the tail.
        send_txn(FUNC_READ,  32'h0, 32'h0, 4'd15);  pace();
        send_txn(FUNC_READ,  32'h0, 32'h0, 4'd0);   pace();
        send_txn(FUNC_POP,   32'h0, 32'h0, 4'd0);   pace();
        send_txn(FUNC_READ,  32'h0, 32'h0, 4'd15);  pace();
        send_txn(FUNC_CLEAR, 32'h0, 32'h0, 4'd0);   pace();
        send_txn(FUNC_POP,   32'h0, 32'h0, 4'd0);   pace();

        // Random part. Each phase has its own mix, from push-heavy to pop-heavy, so the
        // queue keeps crossing between empty and full. Some phases run without gaps.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       push_pct = 85;
                1:       push_pct = 70;
                2:       push_pct = 50;
                3:       push_pct = 30;
                default: push_pct = 15;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = FUNC_CLEAR;
                else if (roll < push_pct)
                    op = FUNC_PUSH;
                else if (roll < push_pct + (100 - push_pct) / 2)
                    op = FUNC_POP;
                else
                    op = FUNC_READ;
                send_txn(op, $urandom, pick_priority(), pick_index());
                pace();
            end
        end

        // All stimulus is in. Drop start, let the last expectation land, then let the
        // block idle for TAIL_CYCLES, in which any stray result would show.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transactions: %0d push, %0d pop, %0d read-at, %0d clear.",
                 issued[0] + issued[1] + issued[2] + issued[3],
                 issued[int'(FUNC_PUSH)], issued[int'(FUNC_POP)],
                 issued[int'(FUNC_READ)], issued[int'(FUNC_CLEAR)]);
        $display("%0d results checked, with %0d dropped pushes, %0d empty pops, %0d bad indexes.",
                 checked, full_seen, empty_seen, badidx_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: ends the run if neither a transaction nor a result moves for too long.
    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid)
                stall = 0;
            else
                stall++;
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_dp.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue.sv
